// ----- rtl/rcc_pkg.sv -----
// Shared types and constants for the rolling checksum chunker.
package rcc_pkg;

   // Field widths fixed by the stream format
   localparam int BYTE_WIDTH          = 8;
   localparam int SUM_WIDTH           = 16;
   localparam int COUNT_WIDTH         = 32;
   localparam int WINDOW_LENGTH_WIDTH = 13;

   // Window store depth default
   localparam int MAX_WINDOW_DEFAULT = 4096;

   // Control and status register port
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_CUT_TARGET    = 1'b1
   } csr_index_type;

   localparam logic [WINDOW_LENGTH_WIDTH-1:0] WINDOW_LENGTH_RESET = 13'd4095;
   localparam logic [SUM_WIDTH-1:0]           CUT_TARGET_RESET    = 16'd0;
   localparam logic [COUNT_WIDTH-1:0]         COUNT_MAX           = 32'hffff_ffff;

   // One request: a byte of the stream
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  end_of_stream;
   } req_type;

   // One response per request
   typedef struct packed {
      logic                   boundary;
      logic                   final_chunk;
      logic [COUNT_WIDTH-1:0] chunk_length;
      logic [31:0]            rolling_sum;
   } rsp_type;

   // Running checksum state of the open chunk
   typedef struct packed {
      logic [SUM_WIDTH-1:0]   low_sum;
      logic [SUM_WIDTH-1:0]   high_sum;
      logic [COUNT_WIDTH-1:0] bytes_in_chunk;
   } sums_type;

endpackage

// ----- rtl/rcc_window_mem.sv -----
// Window byte store with registered read and write-to-read bypass.
module rcc_window_mem #(
   parameter int DEPTH      = 4096,
   parameter int ADDR_WIDTH = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [7:0]            wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [7:0]            rd_data
);
   import rcc_pkg::*;

   logic [BYTE_WIDTH-1:0] window_store_ff [DEPTH];
   logic [BYTE_WIDTH-1:0] rd_data_ff;
   logic                  bypass_ff;
   logic                  bypass_in;
   logic [BYTE_WIDTH-1:0] bypass_data_ff;

   // Write the byte of the request being processed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_store_ff[wr_addr] <= wr_data;
      end
   end

   // Read ahead for the next request
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff     <= window_store_ff[rd_addr];
         bypass_data_ff <= wr_data;
      end
   end

   // Catch a write to the address being read in the same cycle
   assign bypass_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (rd_en) begin
         bypass_ff <= bypass_in;
      end
   end

   assign rd_data = bypass_ff ? bypass_data_ff : rd_data_ff;

endmodule

// ----- rtl/rcc_roll_update.sv -----
// Checksum fill and roll update, cut test and pointer advance for one byte.
module rcc_roll_update #(
   parameter int PTR_WIDTH = 12
) (
   input  rcc_pkg::sums_type          sums,
   input  logic [PTR_WIDTH-1:0]       pos,
   input  logic [PTR_WIDTH:0]         eff_window,
   input  rcc_pkg::req_type           req,
   input  logic [7:0]                 old_byte,
   input  logic [15:0]                cut_target,
   output rcc_pkg::sums_type          sums_next,
   output logic [PTR_WIDTH-1:0]       ptr_next,
   output rcc_pkg::rsp_type           rsp
);
   import rcc_pkg::*;

   logic                   filling;
   logic [SUM_WIDTH-1:0]   low_fill;
   logic [SUM_WIDTH-1:0]   high_fill;
   logic [SUM_WIDTH-1:0]   low_roll;
   logic [SUM_WIDTH-1:0]   high_roll;
   logic [SUM_WIDTH-1:0]   window_lo;
   logic [BYTE_WIDTH:0]    old_inc;
   logic [SUM_WIDTH-1:0]   drop_term;
   logic [SUM_WIDTH-1:0]   low_new;
   logic [SUM_WIDTH-1:0]   high_new;
   logic [COUNT_WIDTH-1:0] count_new;
   logic [COUNT_WIDTH-1:0] window_wide;
   logic                   cut;
   logic                   chunk_end;
   logic [PTR_WIDTH:0]     ptr_adv;

   assign window_wide = COUNT_WIDTH'(eff_window);
   assign filling     = sums.bytes_in_chunk < window_wide;

   // Fill: add byte plus one, then fold the low sum into the high sum
   assign low_fill  = sums.low_sum + SUM_WIDTH'(req.data_byte) + 16'd1;
   assign high_fill = sums.high_sum + low_fill;

   // Roll: drop the byte one window back and add the new one
   assign window_lo = SUM_WIDTH'(eff_window);
   assign old_inc   = {1'b0, old_byte} + 9'd1;
   assign drop_term = SUM_WIDTH'(window_lo * SUM_WIDTH'(old_inc));
   assign low_roll  = sums.low_sum - SUM_WIDTH'(old_byte) + SUM_WIDTH'(req.data_byte);
   assign high_roll = sums.high_sum - drop_term + low_roll;

   assign low_new  = filling ? low_fill : low_roll;
   assign high_new = filling ? high_fill : high_roll;

   // Saturating chunk length
   assign count_new = (sums.bytes_in_chunk == COUNT_MAX) ? sums.bytes_in_chunk
                                                         : sums.bytes_in_chunk + 32'd1;

   // Cut once a full window has been seen
   assign cut       = (count_new >= window_wide) && (low_new == cut_target);
   assign chunk_end = cut || req.end_of_stream;

   // Advance the ring pointer, wrapping at the window
   assign ptr_adv = {1'b0, pos} + {{PTR_WIDTH{1'b0}}, 1'b1};

   always_comb begin
      if (chunk_end) begin
         sums_next = '0;
         ptr_next  = '0;
      end else begin
         sums_next.low_sum        = low_new;
         sums_next.high_sum       = high_new;
         sums_next.bytes_in_chunk = count_new;
         ptr_next = (ptr_adv >= eff_window) ? '0 : ptr_adv[PTR_WIDTH-1:0];
      end
   end

   assign rsp.boundary     = chunk_end;
   assign rsp.final_chunk  = req.end_of_stream;
   assign rsp.chunk_length = count_new;
   assign rsp.rolling_sum  = {high_new, low_new};

endmodule

// ----- rtl/rolling_checksum_chunker.sv -----
// Rolling checksum chunker: one response per byte request, input and result registers.
// Each request is held in the input register and its result in the result register.
// Throughput: one request per cycle unless the response stalls; a stall holds the result
//   and input registers, and the window store read is issued as each request is accepted.
// Reset clears the sums, chunk length, ring pointer, both valid flags and the registers
//   (window_length 4095, cut_target 0); the window store is not cleared.
module rolling_checksum_chunker #(
   parameter int MAX_WINDOW = rcc_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rcc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rcc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write_enable,
   input  logic [rcc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rcc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import rcc_pkg::*;

   localparam int PW = $clog2(MAX_WINDOW);
   localparam int WW = PW + 1;

   // Registers
   logic [WINDOW_LENGTH_WIDTH-1:0] window_length_ff;
   logic [SUM_WIDTH-1:0]           cut_target_ff;

   // Pipeline and state
   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   sums_type      sums_ff;
   sums_type      sums_in;
   sums_type      sums_upd;
   logic [PW-1:0] ptr_ff;
   logic [PW-1:0] ptr_in;
   logic [PW-1:0] ptr_upd;

   logic          accept;
   logic          process;
   logic [WW-1:0] eff_window;
   logic [PW-1:0] pos;
   logic [PW-1:0] rd_addr;
   logic [7:0]    old_byte;

   // Clamp the window length to 1..MAX_WINDOW
   always_comb begin
      if (window_length_ff == '0) begin
         eff_window = WW'(1);
      end else if (32'(window_length_ff) > 32'(MAX_WINDOW)) begin
         eff_window = WW'(MAX_WINDOW);
      end else begin
         eff_window = WW'(window_length_ff);
      end
   end

   // Handshake: process when the result register is free or draining
   assign process   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;
   assign accept    = req_valid && !req_stall;

   // Wrap a stale pointer after a window change
   assign pos = ({1'b0, ptr_ff} >= eff_window) ? '0 : ptr_ff;

   rcc_roll_update #(
      .PTR_WIDTH (PW)
   ) u_roll (
      .sums       (sums_ff),
      .pos        (pos),
      .eff_window (eff_window),
      .req        (in_ff),
      .old_byte   (old_byte),
      .cut_target (cut_target_ff),
      .sums_next  (sums_upd),
      .ptr_next   (ptr_upd),
      .rsp        (rsp_in)
   );

   // Next state
   always_comb begin
      sums_in      = process ? sums_upd : sums_ff;
      ptr_in       = process ? ptr_upd : ptr_ff;
      in_valid_in  = accept ? 1'b1 : (process ? 1'b0 : in_valid_ff);
      out_valid_in = process ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   // Read ahead at the position the next request will use
   assign rd_addr = ({1'b0, ptr_in} >= eff_window) ? '0 : ptr_in;

   rcc_window_mem #(
      .DEPTH      (MAX_WINDOW),
      .ADDR_WIDTH (PW)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (process),
      .wr_addr (pos),
      .wr_data (in_ff.data_byte),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (old_byte)
   );

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         sums_ff          <= '0;
         ptr_ff           <= '0;
         window_length_ff <= WINDOW_LENGTH_RESET;
         cut_target_ff    <= CUT_TARGET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sums_ff      <= sums_in;
         ptr_ff       <= ptr_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_WINDOW_LENGTH: window_length_ff <= csr_write_data[WINDOW_LENGTH_WIDTH-1:0];
               CSR_CUT_TARGET:    cut_target_ff    <= csr_write_data[SUM_WIDTH-1:0];
               default: ;
            endcase
         end
      end
   end

   // Hold the request and response payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // A chunk end restarts the sums and the pointer
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      process && rsp_in.boundary |=> (sums_ff == '0) && (ptr_ff == '0))
      else $error("chunk state not cleared after boundary");

   // An accepted request always lands in the input register
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted request lost");

   // A processed request always produces a response
   a_process_emits: assert property (@(posedge clock) disable iff (reset)
      process |=> out_valid_ff && (rsp_ff.chunk_length != '0))
      else $error("processed request gave no response");

   // Stream end always marks a boundary
   a_final_is_boundary: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_ff.final_chunk |-> rsp_ff.boundary)
      else $error("final chunk without boundary");
`endif

endmodule
